FILE: src/text_console_char_engine_assert.svh
// Assertion macros for the text console character engine.
// Used by the port monitor; no other dependencies.
`ifndef TEXT_CONSOLE_CHAR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_ASSERT_SVH

// same-cycle implication, off during reset
`define TCCE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcce: same-cycle check failed");

// next-cycle implication, off during reset
`define TCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcce: next-cycle check failed");

`endif

FILE: src/tcce_pkg.sv
// Shared types and constants of the text console character engine.
// No dependencies.
package tcce_pkg;

    localparam int COLUMNS_DEF   = 80;
    localparam int ROWS_DEF      = 25;
    localparam int TAB_WIDTH_DEF = 8;

    localparam int CELL_W = 16;
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    typedef enum logic [1:0] {
        CMD_CHAR = 2'd0,
        CMD_END  = 2'd1,
        CMD_READ = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_PRINT_MAX = 8'h7F;

    localparam logic [1:0] LVL_INFO  = 2'd0;
    localparam logic [1:0] LVL_WARN  = 2'd1;
    localparam logic [1:0] LVL_ERROR = 2'd2;

    localparam logic [APB_AW-3:0] REG_ERASE   = 3'd0;
    localparam logic [APB_AW-3:0] REG_INFO    = 3'd1;
    localparam logic [APB_AW-3:0] REG_WARN    = 3'd2;
    localparam logic [APB_AW-3:0] REG_ERROR   = 3'd3;
    localparam logic [APB_AW-3:0] REG_DEFAULT = 3'd4;

    localparam logic [7:0] ERASE_ATTR_RST   = 8'd7;
    localparam logic [7:0] INFO_ATTR_RST    = 8'd10;
    localparam logic [7:0] WARN_ATTR_RST    = 8'd14;
    localparam logic [7:0] ERROR_ATTR_RST   = 8'd4;
    localparam logic [7:0] DEFAULT_ATTR_RST = 8'd7;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUT,
        OP_BS,
        OP_LF,
        OP_CR,
        OP_TAB
    } cur_op_t;

    typedef struct packed {
        logic    step;
        cur_op_t op;
    } cur_cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_BLANK
    } state_t;

endpackage

FILE: src/tcce_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies beyond tcce_pkg defaults.
module tcce_ram #(
    parameter int WIDTH = tcce_pkg::CELL_W,
    parameter int DEPTH = tcce_pkg::COLUMNS_DEF * tcce_pkg::ROWS_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/tcce_cursor.sv
// Cursor unit: linear position plus column, tab and row-base remainders.
// Depends on tcce_pkg.
module tcce_cursor #(
    parameter int COLUMNS   = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS      = tcce_pkg::ROWS_DEF,
    parameter int TAB_WIDTH = tcce_pkg::TAB_WIDTH_DEF,
    localparam int CELLS = COLUMNS * ROWS,
    localparam int POS_W = $clog2(CELLS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tcce_pkg::cur_cmd_t  cmd,
    output logic [POS_W-1:0]    pos,
    output logic [POS_W-1:0]    pos_next,
    output logic                scroll
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int TRW   = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
    localparam int NPW   = $clog2(CELLS + COLUMNS + TAB_WIDTH);
    localparam int C2W   = $clog2(COLUMNS + TAB_WIDTH + 1);
    localparam int WRAPS = (TAB_WIDTH + COLUMNS - 1) / COLUMNS;

    localparam logic [TRW:0]     TW_V     = (TRW + 1)'(TAB_WIDTH);
    localparam logic [TRW:0]     CMOD     = (TRW + 1)'(COLUMNS % TAB_WIDTH);
    localparam logic [TRW:0]     ONE_M    = (TRW + 1)'(1);
    localparam logic [NPW-1:0]   CELLS_N  = NPW'(CELLS);
    localparam logic [NPW-1:0]   LAST_N   = NPW'(CELLS - 1);
    localparam logic [NPW-1:0]   COLS_N   = NPW'(COLUMNS);
    localparam logic [NPW-1:0]   TW_N     = NPW'(TAB_WIDTH);
    localparam logic [CW-1:0]    COL_LAST = CW'(COLUMNS - 1);
    localparam logic [C2W-1:0]   COLS_C   = C2W'(COLUMNS);
    localparam logic [C2W-1:0]   TW_C     = C2W'(TAB_WIDTH);
    localparam logic [TRW-1:0]   TR_LAST  = TRW'((CELLS - 1) % TAB_WIDTH);
    localparam logic [TRW-1:0]   RB_LAST  = TRW'((CELLS - COLUMNS) % TAB_WIDTH);

    logic [POS_W-1:0] pos_reg;
    logic [CW-1:0]    col_reg, col_next;
    logic [TRW-1:0]   tr_reg, tr_next;
    logic [TRW-1:0]   rb_reg, rb_next;
    logic [NPW-1:0]   np;
    logic [C2W-1:0]   c2;
    logic             scr;

    function automatic logic [TRW-1:0] add_mod(input logic [TRW-1:0] a, input logic [TRW:0] k);
        logic [TRW:0] s;
        s = {1'b0, a} + k;
        if (s >= TW_V)
        begin
            s = s - TW_V;
        end
        return s[TRW-1:0];
    endfunction

    function automatic logic [TRW-1:0] sub_mod(input logic [TRW-1:0] a, input logic [TRW:0] k);
        logic [TRW:0] s;
        s = {1'b0, a} + TW_V - k;
        if (s >= TW_V)
        begin
            s = s - TW_V;
        end
        return s[TRW-1:0];
    endfunction

    always_comb
    begin
        np       = NPW'(pos_reg);
        col_next = col_reg;
        tr_next  = tr_reg;
        rb_next  = rb_reg;
        c2       = '0;
        scr      = 1'b0;
        unique case (cmd.op)
            tcce_pkg::OP_PUT:
            begin
                np = np + 1'b1;
                if (col_reg == COL_LAST)
                begin
                    col_next = '0;
                    rb_next  = add_mod(rb_reg, CMOD);
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
                tr_next = add_mod(tr_reg, ONE_M);
            end
            tcce_pkg::OP_BS:
            begin
                if (col_reg != '0)
                begin
                    np       = np - 1'b1;
                    col_next = col_reg - 1'b1;
                    tr_next  = sub_mod(tr_reg, ONE_M);
                end
            end
            tcce_pkg::OP_CR:
            begin
                np       = np - NPW'(col_reg);
                col_next = '0;
                tr_next  = rb_reg;
            end
            tcce_pkg::OP_LF:
            begin
                np       = np - NPW'(col_reg) + COLS_N;
                col_next = '0;
                rb_next  = add_mod(rb_reg, CMOD);
                tr_next  = rb_next;
            end
            tcce_pkg::OP_TAB:
            begin
                np = np - NPW'(tr_reg) + TW_N;
                c2 = C2W'(col_reg) + TW_C - C2W'(tr_reg);
                // tab may cross one or more row ends
                for (int k = 0; k < WRAPS; k++)
                begin
                    if (c2 >= COLS_C)
                    begin
                        c2      = c2 - COLS_C;
                        rb_next = add_mod(rb_next, CMOD);
                    end
                end
                col_next = c2[CW-1:0];
                tr_next  = '0;
            end
            tcce_pkg::OP_NONE:
            begin
            end
            default:
            begin
            end
        endcase

        if (np >= CELLS_N)
        begin
            scr     = 1'b1;
            np      = np - COLS_N;
            rb_next = sub_mod(rb_next, CMOD);
            tr_next = sub_mod(tr_next, CMOD);
            if (np >= CELLS_N)
            begin
                np       = LAST_N;
                col_next = COL_LAST;
                tr_next  = TR_LAST;
                rb_next  = RB_LAST;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            col_reg <= '0;
            tr_reg  <= '0;
            rb_reg  <= '0;
        end
        else if (cmd.step)
        begin
            pos_reg <= np[POS_W-1:0];
            col_reg <= col_next;
            tr_reg  <= tr_next;
            rb_reg  <= rb_next;
        end
    end

    assign pos      = pos_reg;
    assign pos_next = np[POS_W-1:0];
    assign scroll   = scr;

endmodule

FILE: src/text_console_char_engine.sv
// Top level of the text console character engine: APB registers, control FSM,
// cell RAM and cursor unit. Depends on tcce_pkg, tcce_ram, tcce_cursor.
//
//  channel   direction  handshake            payload
//  apb       in/out     psel,penable,pready  paddr, pwdata, prdata
//  in        in         in_valid/in_ready    cmd, char_code, level, cell_addr
//  out       out        out_valid/out_ready  cursor_pos, read_char, read_attr, scrolled
//
// Character and message-end items are taken back to back while the result register drains.
// Read items wait in ST_READ for the registered RAM read before the next item is taken.
// A scrolling item then copies the rows up through the RAM port pair (ST_COPY),
// then blank-fills the last row (ST_BLANK). Its result is presented at once.
// After reset a clearing pass over all CELLS cells runs before the first transfer.
// in_ready needs the result register empty or draining.
module text_console_char_engine #(
    parameter int COLUMNS   = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS      = tcce_pkg::ROWS_DEF,
    parameter int TAB_WIDTH = tcce_pkg::TAB_WIDTH_DEF,
    localparam int CELLS = COLUMNS * ROWS,
    localparam int POS_W = $clog2(CELLS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcce_pkg::APB_AW-1:0]   paddr,
    input  logic [tcce_pkg::APB_DW-1:0]   pwdata,
    output logic [tcce_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    cmd,
    input  logic [7:0]                    char_code,
    input  logic [1:0]                    level,
    input  logic [POS_W-1:0]              cell_addr,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [POS_W-1:0]              cursor_pos,
    output logic [7:0]                    read_char,
    output logic [7:0]                    read_attr,
    output logic                          scrolled
);

    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int AW    = POS_W;

    localparam logic [CNT_W-1:0] CELLS_C    = CNT_W'(CELLS);
    localparam logic [CNT_W-1:0] LAST_C     = CNT_W'(CELLS - 1);
    localparam logic [CNT_W-1:0] COLS_C     = CNT_W'(COLUMNS);
    localparam logic [CNT_W-1:0] LASTROW_C  = CNT_W'(CELLS - COLUMNS);
    localparam logic [POS_W:0]   CELLS_P    = (POS_W + 1)'(CELLS);

    // configuration registers
    logic [7:0] erase_attr_reg, info_attr_reg, warn_attr_reg, error_attr_reg, default_attr_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erase_attr_reg   <= tcce_pkg::ERASE_ATTR_RST;
            info_attr_reg    <= tcce_pkg::INFO_ATTR_RST;
            warn_attr_reg    <= tcce_pkg::WARN_ATTR_RST;
            error_attr_reg   <= tcce_pkg::ERROR_ATTR_RST;
            default_attr_reg <= tcce_pkg::DEFAULT_ATTR_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[tcce_pkg::APB_AW-1:2])
                tcce_pkg::REG_ERASE:   erase_attr_reg   <= pwdata[7:0];
                tcce_pkg::REG_INFO:    info_attr_reg    <= pwdata[7:0];
                tcce_pkg::REG_WARN:    warn_attr_reg    <= pwdata[7:0];
                tcce_pkg::REG_ERROR:   error_attr_reg   <= pwdata[7:0];
                tcce_pkg::REG_DEFAULT: default_attr_reg <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[tcce_pkg::APB_AW-1:2])
            tcce_pkg::REG_ERASE:   prdata = (tcce_pkg::APB_DW)'(erase_attr_reg);
            tcce_pkg::REG_INFO:    prdata = (tcce_pkg::APB_DW)'(info_attr_reg);
            tcce_pkg::REG_WARN:    prdata = (tcce_pkg::APB_DW)'(warn_attr_reg);
            tcce_pkg::REG_ERROR:   prdata = (tcce_pkg::APB_DW)'(error_attr_reg);
            tcce_pkg::REG_DEFAULT: prdata = (tcce_pkg::APB_DW)'(default_attr_reg);
            default:               prdata = '0;
        endcase
    end

    // control
    tcce_pkg::state_t   state_reg, state_next;
    tcce_pkg::cmd_t     cmd_e;
    tcce_pkg::cur_op_t  op;
    tcce_pkg::cur_cmd_t cur_cmd;
    logic [CNT_W-1:0]   cnt_reg, cnt_next, copy_dst;
    logic [AW-1:0]      waddr_reg, waddr_next;
    logic               wpend_reg, wpend_next;
    logic               skip_reg, skip_next;
    logic               rd_ok_reg, rd_ok_next;
    logic [7:0]         blank_attr_reg, blank_attr_next;
    logic [7:0]         attr;
    logic               accept;

    logic               out_valid_reg, out_valid_next;
    logic [POS_W-1:0]   cur_out_reg, cur_out_next;
    logic [7:0]         rchar_out_reg, rchar_out_next;
    logic [7:0]         rattr_out_reg, rattr_out_next;
    logic               scr_out_reg, scr_out_next;
    logic               load_out;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [15:0]        mem_wdata, mem_rdata;

    logic [POS_W-1:0]   cur_pos, cur_pos_next;
    logic               cur_scroll;

    assign cmd_e    = tcce_pkg::cmd_t'(cmd);
    assign in_ready = (state_reg == tcce_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid & in_ready;
    assign copy_dst = cnt_reg - COLS_C;

    always_comb
    begin
        case (level)
            tcce_pkg::LVL_INFO:  attr = info_attr_reg;
            tcce_pkg::LVL_WARN:  attr = warn_attr_reg;
            tcce_pkg::LVL_ERROR: attr = error_attr_reg;
            default:             attr = default_attr_reg;
        endcase
    end

    always_comb
    begin
        op        = tcce_pkg::OP_NONE;
        skip_next = skip_reg;
        unique case (cmd_e)
            tcce_pkg::CMD_CHAR:
            begin
                if (!skip_reg)
                begin
                    unique case (char_code) inside
                        tcce_pkg::CH_NUL: skip_next = 1'b1;
                        tcce_pkg::CH_BS:  op = tcce_pkg::OP_BS;
                        tcce_pkg::CH_TAB: op = tcce_pkg::OP_TAB;
                        tcce_pkg::CH_LF:  op = tcce_pkg::OP_LF;
                        tcce_pkg::CH_CR:  op = tcce_pkg::OP_CR;
                        [tcce_pkg::CH_SPACE:tcce_pkg::CH_PRINT_MAX]: op = tcce_pkg::OP_PUT;
                        default:          op = tcce_pkg::OP_NONE;
                    endcase
                end
            end
            tcce_pkg::CMD_END:
            begin
                op        = tcce_pkg::OP_LF;
                skip_next = 1'b0;
            end
            tcce_pkg::CMD_READ, tcce_pkg::CMD_NOP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        waddr_next      = waddr_reg;
        wpend_next      = 1'b0;
        rd_ok_next      = rd_ok_reg;
        blank_attr_next = blank_attr_reg;
        mem_we          = 1'b0;
        mem_waddr       = cnt_reg[AW-1:0];
        mem_wdata       = {blank_attr_reg, tcce_pkg::CH_SPACE};
        mem_raddr       = cnt_reg[AW-1:0];
        cur_cmd.step    = 1'b0;
        cur_cmd.op      = op;
        load_out        = 1'b0;
        cur_out_next    = cur_pos_next;
        rchar_out_next  = '0;
        rattr_out_next  = '0;
        scr_out_next    = 1'b0;

        unique case (state_reg)
            tcce_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {tcce_pkg::ERASE_ATTR_RST, tcce_pkg::CH_SPACE};
                if (cnt_reg == LAST_C)
                begin
                    cnt_next   = '0;
                    state_next = tcce_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            tcce_pkg::ST_IDLE:
            begin
                mem_raddr = cell_addr;
                mem_waddr = cur_pos;
                mem_wdata = {attr, char_code};
                if (accept)
                begin
                    cur_cmd.step = 1'b1;
                    mem_we       = (op == tcce_pkg::OP_PUT);
                    rd_ok_next   = ({1'b0, cell_addr} < CELLS_P);
                    if (cmd_e == tcce_pkg::CMD_READ)
                    begin
                        state_next = tcce_pkg::ST_READ;
                    end
                    else
                    begin
                        load_out     = 1'b1;
                        scr_out_next = cur_scroll;
                        if (cur_scroll)
                        begin
                            blank_attr_next = erase_attr_reg;
                            cnt_next        = COLS_C;
                            state_next      = tcce_pkg::ST_COPY;
                        end
                    end
                end
            end
            tcce_pkg::ST_READ:
            begin
                load_out     = 1'b1;
                cur_out_next = cur_pos;
                if (rd_ok_reg)
                begin
                    rchar_out_next = mem_rdata[7:0];
                    rattr_out_next = mem_rdata[15:8];
                end
                state_next = tcce_pkg::ST_IDLE;
            end
            tcce_pkg::ST_COPY:
            begin
                // read row below, write it one row up in the next cycle
                mem_we    = wpend_reg;
                mem_waddr = waddr_reg;
                mem_wdata = mem_rdata;
                if (cnt_reg < CELLS_C)
                begin
                    wpend_next = 1'b1;
                    waddr_next = copy_dst[AW-1:0];
                    cnt_next   = cnt_reg + 1'b1;
                end
                else
                begin
                    cnt_next   = LASTROW_C;
                    state_next = tcce_pkg::ST_BLANK;
                end
            end
            tcce_pkg::ST_BLANK:
            begin
                mem_we = 1'b1;
                if (cnt_reg == LAST_C)
                begin
                    cnt_next   = '0;
                    state_next = tcce_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcce_pkg::ST_CLEAR;
            cnt_reg       <= '0;
            wpend_reg     <= 1'b0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            wpend_reg     <= wpend_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                skip_reg <= skip_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        waddr_reg      <= waddr_next;
        rd_ok_reg      <= rd_ok_next;
        blank_attr_reg <= blank_attr_next;
        if (load_out)
        begin
            cur_out_reg   <= cur_out_next;
            rchar_out_reg <= rchar_out_next;
            rattr_out_reg <= rattr_out_next;
            scr_out_reg   <= scr_out_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cursor_pos = cur_out_reg;
    assign read_char  = rchar_out_reg;
    assign read_attr  = rattr_out_reg;
    assign scrolled   = scr_out_reg;

    tcce_ram #(
        .WIDTH (tcce_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tcce_cursor #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_cursor (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cur_cmd),
        .pos      (cur_pos),
        .pos_next (cur_pos_next),
        .scroll   (cur_scroll)
    );

endmodule

FILE: src/tcce_monitor.sv
// Port-level assertions for the text console character engine, bound to the top.
// Depends on tcce_pkg and text_console_char_engine_assert.svh.
`include "text_console_char_engine_assert.svh"

module tcce_monitor #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcce_pkg::ROWS_DEF,
    localparam int CELLS = COLUMNS * ROWS,
    localparam int POS_W = $clog2(CELLS)
) (
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [POS_W-1:0] cursor_pos,
    input logic [7:0]       read_char,
    input logic [7:0]       read_attr,
    input logic             scrolled
);

    localparam logic [POS_W:0] CELLS_P   = (POS_W + 1)'(CELLS);
    localparam logic [POS_W:0] LASTROW_P = (POS_W + 1)'(CELLS - COLUMNS);

    logic [POS_W:0] pos_x;

    assign pos_x = {1'b0, cursor_pos};

    `TCCE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(cursor_pos))
    `TCCE_ASSERT_IMPLY(a_cursor_range, clk, rst_n, out_valid, pos_x < CELLS_P)
    `TCCE_ASSERT_IMPLY(a_scroll_last_row, clk, rst_n, out_valid && scrolled, pos_x >= LASTROW_P)
    `TCCE_ASSERT_IMPLY(a_scroll_no_read, clk, rst_n, out_valid && scrolled, read_char == 8'd0 && read_attr == 8'd0)

endmodule

bind text_console_char_engine tcce_monitor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcce_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cursor_pos (cursor_pos),
    .read_char  (read_char),
    .read_attr  (read_attr),
    .scrolled   (scrolled)
);

FILE: bench/console_mirror_pkg.sv
// Scoreboard for the text console character engine: a mirror of the cell
// store, cursor and attribute registers that predicts each result.
// Depends on tcce_pkg.
`timescale 1ns / 1ps
package console_mirror_pkg;

    import tcce_pkg::*;

    localparam int SCREEN_CELLS = COLUMNS_DEF * ROWS_DEF;
    localparam int POS_BITS     = $clog2(SCREEN_CELLS);

    typedef struct packed {
        logic [POS_BITS-1:0] cursor_pos;
        logic [7:0]          read_char;
        logic [7:0]          read_attr;
        logic                scrolled;
    } cell_report_t;

    class console_mirror;
        logic [CELL_W-1:0] cells [SCREEN_CELLS];
        int unsigned       cursor;
        bit                muted;
        logic [7:0]        erase_attr;
        logic [7:0]        info_attr;
        logic [7:0]        warn_attr;
        logic [7:0]        error_attr;
        logic [7:0]        default_attr;
        cell_report_t      queued_reports [$];
        int unsigned       failures;

        function new();
            erase_attr   = ERASE_ATTR_RST;
            info_attr    = INFO_ATTR_RST;
            warn_attr    = WARN_ATTR_RST;
            error_attr   = ERROR_ATTR_RST;
            default_attr = DEFAULT_ATTR_RST;
            foreach (cells[i])
                cells[i] = {ERASE_ATTR_RST, CH_SPACE};
            cursor   = 0;
            muted    = 1'b0;
            failures = 0;
        endfunction

        function void write_register(logic [2:0] index, logic [7:0] value);
            case (index)
                REG_ERASE:   erase_attr   = value;
                REG_INFO:    info_attr    = value;
                REG_WARN:    warn_attr    = value;
                REG_ERROR:   error_attr   = value;
                REG_DEFAULT: default_attr = value;
                default: ;
            endcase
        endfunction

        function logic [7:0] attr_for_level(logic [1:0] lvl);
            case (lvl)
                LVL_INFO:  return info_attr;
                LVL_WARN:  return warn_attr;
                LVL_ERROR: return error_attr;
                default:   return default_attr;
            endcase
        endfunction

        // returns 1 when the move pushed the cursor off the screen
        function bit apply_byte(logic [7:0] ch, logic [7:0] attr);
            int unsigned pos;
            pos = cursor;
            case (ch)
                CH_BS:  if (pos % COLUMNS_DEF > 0) pos--;
                CH_LF:  pos = COLUMNS_DEF * (pos / COLUMNS_DEF + 1);
                CH_CR:  pos = COLUMNS_DEF * (pos / COLUMNS_DEF);
                CH_TAB: pos = pos - pos % TAB_WIDTH_DEF + TAB_WIDTH_DEF;
                default:
                begin
                    if (ch >= CH_SPACE && ch <= CH_PRINT_MAX && pos < SCREEN_CELLS)
                    begin
                        cells[pos] = {attr, ch};
                        pos++;
                    end
                end
            endcase
            if (pos >= SCREEN_CELLS)
            begin
                pos -= COLUMNS_DEF;
                if (pos >= SCREEN_CELLS)
                    pos = SCREEN_CELLS - 1;
                cursor = pos;
                for (int i = 0; i < SCREEN_CELLS - COLUMNS_DEF; i++)
                    cells[i] = cells[i + COLUMNS_DEF];
                for (int i = SCREEN_CELLS - COLUMNS_DEF; i < SCREEN_CELLS; i++)
                    cells[i] = {erase_attr, CH_SPACE};
                return 1'b1;
            end
            cursor = pos;
            return 1'b0;
        endfunction

        function void note_item(cmd_t op, logic [7:0] ch, logic [1:0] lvl,
                                logic [POS_BITS-1:0] addr);
            cell_report_t r;
            r = '0;
            case (op)
                CMD_CHAR:
                begin
                    if (!muted)
                    begin
                        if (ch == CH_NUL)
                            muted = 1'b1;
                        else
                            r.scrolled = apply_byte(ch, attr_for_level(lvl));
                    end
                end
                CMD_END:
                begin
                    r.scrolled = apply_byte(CH_LF, default_attr);
                    muted = 1'b0;
                end
                CMD_READ:
                begin
                    if (addr < SCREEN_CELLS)
                    begin
                        r.read_char = cells[addr][7:0];
                        r.read_attr = cells[addr][15:8];
                    end
                end
                default: ;
            endcase
            r.cursor_pos = cursor[POS_BITS-1:0];
            queued_reports.push_back(r);
        endfunction

        function void check_result(cell_report_t got);
            cell_report_t want;
            if (queued_reports.size() == 0)
            begin
                $error("result with none pending: cursor_pos %0d", got.cursor_pos);
                failures++;
                return;
            end
            want = queued_reports.pop_front();
            if (got.cursor_pos !== want.cursor_pos)
            begin
                $error("cursor_pos: expected %0d, actual %0d", want.cursor_pos, got.cursor_pos);
                failures++;
            end
            if (got.read_char !== want.read_char)
            begin
                $error("read_char: expected %02h, actual %02h", want.read_char, got.read_char);
                failures++;
            end
            if (got.read_attr !== want.read_attr)
            begin
                $error("read_attr: expected %02h, actual %02h", want.read_attr, got.read_attr);
                failures++;
            end
            if (got.scrolled !== want.scrolled)
            begin
                $error("scrolled: expected %0b, actual %0b", want.scrolled, got.scrolled);
                failures++;
            end
        endfunction
    endclass

endpackage

FILE: bench/testbench.sv
// Top-level bench for text_console_char_engine: clock, reset, APB setup,
// message stimulus and result sink. Depends on tcce_pkg and console_mirror_pkg.
`timescale 1ns / 1ps
module testbench;

    import tcce_pkg::*;
    import console_mirror_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 10;
    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 290;
    localparam int SETTLE_CYCLES   = SCREEN_CELLS + 2 * COLUMNS_DEF + 32;
    localparam int LONG_HOLD       = 400;
    localparam longint LIMIT_CYCLES = 64'd4 * ((PHASES * ITEMS_PER_PHASE * 2 + 64)
                                      * (SCREEN_CELLS + COLUMNS_DEF + 24)
                                      + (PHASES + 2) * SETTLE_CYCLES + 2 * LONG_HOLD);

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           cmd;
    logic [7:0]           char_code;
    logic [1:0]           level;
    logic [POS_BITS-1:0]  cell_addr;
    logic                 out_valid;
    logic                 out_ready;
    logic [POS_BITS-1:0]  cursor_pos;
    logic [7:0]           read_char;
    logic [7:0]           read_attr;
    logic                 scrolled;

    console_mirror mirror;
    int            sender_calm = 0;
    int            phase_items = 0;

    text_console_char_engine DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .char_code  (char_code),
        .level      (level),
        .cell_addr  (cell_addr),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cursor_pos (cursor_pos),
        .read_char  (read_char),
        .read_attr  (read_attr),
        .scrolled   (scrolled)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                mirror.note_item(cmd_t'(cmd), char_code, level, cell_addr);
            if (out_valid && out_ready)
                mirror.check_result({cursor_pos, read_char, read_attr, scrolled});
        end
    end

    // entered and left at a falling edge
    task automatic send_item(cmd_t op, logic [7:0] ch, logic [1:0] lvl,
                             logic [POS_BITS-1:0] addr);
        int gap;
        gap = $urandom_range(0, 9);
        if (sender_calm > 0)
        begin
            gap = 0;
            sender_calm--;
        end
        else if ($urandom_range(0, 19) == 0)
        begin
            sender_calm = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd       <= op;
        char_code <= ch;
        level     <= lvl;
        cell_addr <= addr;
        in_valid  <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (op != CMD_NOP)
            phase_items++;
        @(negedge clk);
    endtask

    task automatic apb_write(logic [2:0] index, logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= ($urandom() & 32'hFFFF_FF00) | APB_DW'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        mirror.write_register(index, value);
        @(negedge clk);
    endtask

    // waits out the last transfer and any scroll still running, then sets attributes
    task automatic settle_and_configure(int phase);
        logic [7:0] value;
        in_valid <= 1'b0;
        while (mirror.queued_reports.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        for (int r = REG_ERASE; r <= REG_DEFAULT; r++)
        begin
            case (phase)
                0:       value = 8'h00;
                1:       value = 8'hFF;
                default: value = 8'($urandom_range(0, 255));
            endcase
            apb_write(3'(r), value);
        end
        if (phase == 2)
            for (int r = REG_DEFAULT + 1; r < 8; r++)
                apb_write(3'(r), 8'($urandom_range(0, 255)));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [7:0] message_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 78) return 8'($urandom_range(32, 127));
        if (pick < 81) return CH_BS;
        if (pick < 84) return CH_TAB;
        if (pick < 86) return CH_LF;
        if (pick < 88) return CH_CR;
        if (pick < 93) return 8'($urandom_range(128, 255));
        if (pick < 99) return 8'($urandom_range(1, 31));
        return CH_NUL;
    endfunction

    function automatic logic [POS_BITS-1:0] probe_addr();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return POS_BITS'((mirror.cursor + SCREEN_CELLS - $urandom_range(1, 100))
                             % SCREEN_CELLS);
        if (pick < 9)
            return POS_BITS'($urandom_range(0, SCREEN_CELLS - 1));
        return POS_BITS'($urandom_range(SCREEN_CELLS, 2 ** POS_BITS - 1));
    endfunction

    function automatic logic [POS_BITS-1:0] any_addr();
        return POS_BITS'($urandom_range(0, 2 ** POS_BITS - 1));
    endfunction

    task automatic random_message();
        int         len;
        logic [1:0] lvl;
        lvl = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0)
            len = $urandom_range(60, 240);
        else
            len = $urandom_range(1, 30);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                lvl = 2'($urandom_range(0, 3));
            send_item(CMD_CHAR, message_byte(), lvl, any_addr());
        end
        // a few messages run on without a terminator
        if ($urandom_range(0, 19) != 0)
            send_item(CMD_END, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                      any_addr());
    endtask

    task automatic directed_items();
        send_item(CMD_READ, 8'h00, LVL_INFO, '0);
        send_item(CMD_READ, 8'h00, LVL_INFO, POS_BITS'(SCREEN_CELLS - 1));
        send_item(CMD_READ, 8'h00, LVL_INFO, POS_BITS'(SCREEN_CELLS));
        send_item(CMD_READ, 8'hFF, 2'd3, '1);
        send_item(CMD_NOP, 8'hFF, 2'd3, '1);
        send_item(CMD_CHAR, 8'h41, LVL_INFO, any_addr());
        send_item(CMD_CHAR, CH_PRINT_MAX, LVL_WARN, any_addr());
        send_item(CMD_CHAR, CH_SPACE, LVL_ERROR, any_addr());
        send_item(CMD_CHAR, 8'h7E, 2'd3, any_addr());
        send_item(CMD_CHAR, 8'h80, LVL_INFO, any_addr());
        send_item(CMD_CHAR, 8'hFF, LVL_INFO, any_addr());
        send_item(CMD_CHAR, 8'h1F, LVL_INFO, any_addr());
        send_item(CMD_CHAR, CH_BS, LVL_INFO, any_addr());
        send_item(CMD_CHAR, CH_CR, LVL_INFO, any_addr());
        send_item(CMD_CHAR, CH_BS, LVL_INFO, any_addr());
        send_item(CMD_CHAR, CH_TAB, LVL_INFO, any_addr());
        send_item(CMD_CHAR, CH_LF, LVL_INFO, any_addr());
        send_item(CMD_CHAR, CH_NUL, LVL_INFO, any_addr());
        send_item(CMD_CHAR, 8'h58, LVL_WARN, any_addr());
        send_item(CMD_CHAR, CH_LF, LVL_WARN, any_addr());
        send_item(CMD_END, 8'h00, LVL_INFO, any_addr());
        send_item(CMD_CHAR, 8'h59, LVL_ERROR, any_addr());
        send_item(CMD_READ, 8'h00, LVL_INFO, '0);
        send_item(CMD_READ, 8'h00, LVL_INFO, POS_BITS'(2 * COLUMNS_DEF));
        send_item(CMD_END, 8'hFF, 2'd3, any_addr());
    endtask

    initial
    begin
        int pick;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        cmd       = CMD_CHAR;
        char_code = 8'h00;
        level     = LVL_INFO;
        cell_addr = '0;
        mirror    = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_items();
        for (int p = 0; p < PHASES; p++)
        begin
            settle_and_configure(p);
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    random_message();
                end
                else if (pick < 9)
                begin
                    repeat ($urandom_range(1, 4))
                        send_item(CMD_READ, 8'($urandom_range(0, 255)),
                                  2'($urandom_range(0, 3)), probe_addr());
                end
                else
                begin
                    send_item(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              2'($urandom_range(0, 3)), any_addr());
                end
            end
        end

        in_valid <= 1'b0;
        while (mirror.queued_reports.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mirror.failures == 0 && mirror.queued_reports.size() == 0)
            $display("text_console_char_engine: match");
        else
            $display("text_console_char_engine: mismatch");
        $finish;
    end

    initial
    begin : result_sink
        int stall;
        int calm;
        int taken;
        out_ready = 1'b0;
        calm  = 0;
        taken = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = $urandom_range(0, 9);
            // long hold-offs back the engine up into its input
            if (taken == 150 || taken == 900)
            begin
                stall = LONG_HOLD;
            end
            else if (calm > 0)
            begin
                stall = 0;
                calm--;
            end
            else if ($urandom_range(0, 19) == 0)
            begin
                calm = $urandom_range(10, 40);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
            @(negedge clk);
        end
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("text_console_char_engine: mismatch");
        $finish;
    end

endmodule
